### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdag_pkg.sv
// ----------------------------------------------------------------------------
// sdag_pkg
// Shared types and constants of the strided DMA address generator.
// ----------------------------------------------------------------------------
package sdag_pkg;

  localparam int LocalAddrBits = 12;
  localparam int MainAddrBits  = 24;
  localparam int LenWordBits   = 32;
  localparam int RowLenBits    = 13;
  localparam int RowCntBits    = 9;
  localparam int SkipBits      = 12;
  localparam int SwzBits       = 3;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrBits  = 1;
  localparam int QueueCntBits  = 2;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    action_e                  action;
    logic                     bank;
    logic                     dir;
    logic [LocalAddrBits-1:0] local_ptr;
    logic [MainAddrBits-1:0]  main_ptr;
    logic [RowLenBits-1:0]    row_length;
    logic [RowCntBits-1:0]    rows;
    logic [SkipBits-1:0]      skip;
  } cmd_t;

  // Push side of the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

### rtl/sdag_front.sv
// ----------------------------------------------------------------------------
// sdag_front
// Accepts input transfers and decodes them into start or step commands.
// ----------------------------------------------------------------------------
module sdag_front import sdag_pkg::*; (
  input  logic                     in_valid_i,
  input  logic                     action_i,
  input  logic [12:0]              local_address_i,
  input  logic [MainAddrBits-1:0]  main_address_i,
  input  logic [LenWordBits-1:0]   length_word_i,
  input  logic                     to_main_i,
  input  logic                     push_ready_i,
  output logic                     in_stall_o,
  output push_t                    push_o
);

  logic [11:0] len_field;

  assign len_field = length_word_i[11:0] | 12'h007;

  always_comb begin
    push_o.valid          = in_valid_i;
    push_o.cmd.action     = action_e'(action_i);
    push_o.cmd.bank       = local_address_i[12];
    push_o.cmd.dir        = to_main_i;
    push_o.cmd.local_ptr  = local_address_i[LocalAddrBits-1:0];
    push_o.cmd.main_ptr   = main_address_i;
    // length rounded up to a multiple of 8 bytes, stored as the byte count
    push_o.cmd.row_length = {1'b0, len_field} + RowLenBits'(1);
    push_o.cmd.rows       = {1'b0, length_word_i[19:12]} + RowCntBits'(1);
    push_o.cmd.skip       = length_word_i[31:20];
  end

  assign in_stall_o = !push_ready_i;

endmodule

### rtl/sdag_queue.sv
// ----------------------------------------------------------------------------
// sdag_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sdag_queue import sdag_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output cmd_t  pop_cmd_o,
  input  logic  pop_i
);

  cmd_t                    mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntBits-1:0] count_q, count_d;
  logic                    do_push, do_pop;

  // ready comes from the count only, so a full queue refuses a push even while it pops
  assign push_ready_o = (count_q != QueueCntBits'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrBits'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QueuePtrBits'(1) : rd_ptr_q;
    count_d  = count_q;
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + QueueCntBits'(1);
      2'b01:   count_d = count_q - QueueCntBits'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

### rtl/sdag_back.sv
// ----------------------------------------------------------------------------
// sdag_back
// Transfer state and address stepping, with the registered result stage.
// ----------------------------------------------------------------------------
module sdag_back import sdag_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [SwzBits-1:0]       cfg_data_i,
  input  logic                     cmd_valid_i,
  input  cmd_t                     cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     bank_select_o,
  output logic [LocalAddrBits-1:0] local_byte_o,
  output logic [MainAddrBits-1:0]  main_byte_o,
  output logic                     toward_main_o,
  output logic                     final_move_o
);

  logic [SwzBits-1:0]       swz_q;
  logic                     active_q, active_d;
  logic [LocalAddrBits-1:0] local_q, local_d;
  logic [MainAddrBits-1:0]  main_q, main_d;
  logic                     bank_q, bank_d;
  logic                     dir_q, dir_d;
  logic [RowLenBits-1:0]    row_len_q, row_len_d;
  logic [RowLenBits-1:0]    byte_q, byte_d;
  logic [RowCntBits-1:0]    rows_q, rows_d;
  logic [SkipBits-1:0]      skip_q, skip_d;

  logic                     out_valid_q, out_valid_d;
  logic                     o_bank_q, o_dir_q, o_final_q;
  logic [LocalAddrBits-1:0] o_local_q;
  logic [MainAddrBits-1:0]  o_main_q;

  logic out_free, take, emit, last_in_row, last;
  logic [RowLenBits-1:0]    rows_dec_unused;
  logic [RowCntBits-1:0]    rows_dec;
  logic [MainAddrBits-1:0]  skip_add;

  assign out_free    = !out_valid_q || !out_stall_i;
  // starts never produce a result, so they go regardless of the output stage
  assign take        = cmd_valid_i && ((cmd_i.action == ACT_START) || out_free);
  assign cmd_pop_o   = take;
  assign emit        = take && (cmd_i.action == ACT_STEP) && active_q;
  assign last_in_row = ({1'b0, byte_q} + (RowLenBits+1)'(1)) == {1'b0, row_len_q};
  assign last        = last_in_row && (rows_q == RowCntBits'(1));
  assign rows_dec    = rows_q - RowCntBits'(1);
  assign skip_add    = last_in_row ? MainAddrBits'(skip_q) : '0;
  assign rows_dec_unused = '0;

  always_comb begin
    active_d  = active_q;
    local_d   = local_q;
    main_d    = main_q;
    bank_d    = bank_q;
    dir_d     = dir_q;
    row_len_d = row_len_q;
    byte_d    = byte_q;
    rows_d    = rows_q;
    skip_d    = skip_q;
    if (take) begin
      case (cmd_i.action)
        ACT_START: begin
          active_d  = 1'b1;
          local_d   = cmd_i.local_ptr;
          main_d    = cmd_i.main_ptr;
          bank_d    = cmd_i.bank;
          dir_d     = cmd_i.dir;
          row_len_d = cmd_i.row_length;
          byte_d    = '0;
          rows_d    = cmd_i.rows;
          skip_d    = cmd_i.skip;
        end
        default: begin
          if (active_q) begin
            local_d = local_q + LocalAddrBits'(1);
            main_d  = main_q + MainAddrBits'(1) + skip_add;
            byte_d  = byte_q + RowLenBits'(1) + rows_dec_unused;
            if (last_in_row) begin
              byte_d = '0;
              rows_d = rows_dec;
              if (rows_dec == '0) begin
                active_d = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swz_q       <= '0;
      active_q    <= 1'b0;
      local_q     <= '0;
      main_q      <= '0;
      bank_q      <= 1'b0;
      dir_q       <= 1'b0;
      row_len_q   <= '0;
      byte_q      <= '0;
      rows_q      <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        swz_q <= cfg_data_i;
      end
      active_q    <= active_d;
      local_q     <= local_d;
      main_q      <= main_d;
      bank_q      <= bank_d;
      dir_q       <= dir_d;
      row_len_q   <= row_len_d;
      byte_q      <= byte_d;
      rows_q      <= rows_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      o_bank_q  <= bank_q;
      o_dir_q   <= dir_q;
      o_final_q <= last;
      o_local_q <= local_q ^ LocalAddrBits'(swz_q);
      o_main_q  <= main_q ^ MainAddrBits'(swz_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bank_select_o = o_bank_q;
  assign local_byte_o  = o_local_q;
  assign main_byte_o   = o_main_q;
  assign toward_main_o = o_dir_q;
  assign final_move_o  = o_final_q;

endmodule

### rtl/strided_dma_address_generator.sv
// ----------------------------------------------------------------------------
// strided_dma_address_generator
// Strided 2D DMA address generator: one byte-move address pair per step.
// ----------------------------------------------------------------------------
// A start transfer (action 0) loads a new 2D job and yields no result; each
// step transfer (action 1) then yields one swizzled local/main byte address
// pair, with final_move set on the last byte of the job. Steps while idle
// are dropped, and a start during a job replaces it. The block sustains one
// transfer per cycle: the front decodes into a two-entry command queue, the
// back advances the pointers once per step and holds its result in an
// output register, so a stalled output blocks only steps, and the input
// stalls once the queue is full. byte_swizzle is written through the
// config channel, which is always ready; write it only while no job is in
// flight.
module strided_dma_address_generator import sdag_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [SwzBits-1:0]       cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [12:0]              local_address_i,
  input  logic [MainAddrBits-1:0]  main_address_i,
  input  logic [LenWordBits-1:0]   length_word_i,
  input  logic                     to_main_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     bank_select_o,
  output logic [LocalAddrBits-1:0] local_byte_o,
  output logic [MainAddrBits-1:0]  main_byte_o,
  output logic                     toward_main_o,
  output logic                     final_move_o
);

  push_t push;
  logic  push_ready;
  logic  q_valid;
  cmd_t  q_cmd;
  logic  q_pop;

  // the swizzle register sits in the back; writes never stall
  assign cfg_ready_o = 1'b1;

  sdag_front u_front (
    .in_valid_i      (in_valid_i),
    .action_i        (action_i),
    .local_address_i (local_address_i),
    .main_address_i  (main_address_i),
    .length_word_i   (length_word_i),
    .to_main_i       (to_main_i),
    .push_ready_i    (push_ready),
    .in_stall_o      (in_stall_o),
    .push_o          (push)
  );

  sdag_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_cmd_o    (q_cmd),
    .pop_i        (q_pop)
  );

  sdag_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bank_select_o (bank_select_o),
    .local_byte_o  (local_byte_o),
    .main_byte_o   (main_byte_o),
    .toward_main_o (toward_main_o),
    .final_move_o  (final_move_o)
  );

endmodule

### rtl/sdag_checker.sv
// ----------------------------------------------------------------------------
// sdag_checker
// Port-level checks of the strided DMA address generator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdag_checker import sdag_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     action_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     bank_select_o,
  input logic [LocalAddrBits-1:0] local_byte_o,
  input logic [MainAddrBits-1:0]  main_byte_o,
  input logic                     toward_main_o,
  input logic                     final_move_o
);

  logic seen_start_q;
  logic [LocalAddrBits+MainAddrBits+2:0] out_payload;

  assign out_payload = {bank_select_o, local_byte_o, main_byte_o, toward_main_o, final_move_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_start_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o && (action_i == ACT_START)) begin
      seen_start_q <= 1'b1;
    end
  end

  // a held result keeps its payload
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_payload), "held result changed")

  // no result before any job was loaded
  `ASSERT_IMPLY(a_no_result_idle, clk_i, rst_ni, out_valid_o, seen_start_q, "result before start")

  // the queue fills only behind a stalled result
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o, "stall, output empty")

endmodule

bind strided_dma_address_generator sdag_checker u_sdag_checker (.*);

### tb/strided_dma_address_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_dma_address_generator_tb
// Self-checking bench: table-driven directed transfers, then random 2D jobs.
// ----------------------------------------------------------------------------
// Every accepted input transfer goes through a local model of the address
// generator. Each step that should produce a move queues the expected
// address pair. The monitor pops one expectation per accepted result and
// compares it field by field. The byte swizzle is rewritten between phases
// once all moves have drained. Both sides insert random idle cycles. One
// phase opens with a long output hold-off so that the command queue fills
// and the input stalls.
// ----------------------------------------------------------------------------
module strided_dma_address_generator_tb;
  import sdag_pkg::*;

  // One input transfer, as seen on the ports.
  typedef struct packed {
    action_e                  action;
    logic [12:0]              local_address;
    logic [MainAddrBits-1:0]  main_address;
    logic [LenWordBits-1:0]   length_word;
    logic                     to_main;
  } dma_cmd_t;

  // One byte-move result.
  typedef struct packed {
    logic                     bank_select;
    logic [LocalAddrBits-1:0] local_byte;
    logic [MainAddrBits-1:0]  main_byte;
    logic                     toward_main;
    logic                     final_move;
  } dma_move_t;

  // Directed row: command, plus a hand-written move where it is obvious.
  typedef struct packed {
    dma_cmd_t  cmd;
    logic      typed;
    logic      yields;
    dma_move_t mv;
  } dir_row_t;

  localparam int          DirRows       = 25;
  localparam int          Phases        = 6;
  localparam int          ItemsPerPhase = 216;
  localparam int          LongHold      = 80;
  localparam int          SettleCycles  = 8;
  localparam int unsigned CycleLimit    = 400000;

  localparam logic      Typed   = 1'b1;
  localparam logic      Predict = 1'b0;
  localparam logic      Moves   = 1'b1;
  localparam logic      Silent  = 1'b0;
  localparam dma_move_t NoMove  = '0;

  // Swizzle stays 0 throughout the table, so typed moves are raw pointers.
  localparam dir_row_t DirTab [DirRows] = '{
    // step while idle: nothing
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Typed, Silent, NoMove},
    // instruction bank, both pointers one byte below their wrap, 8 x 1 job
    {ACT_START, 13'h1FFF, 24'hFFFFFF, 32'h00000000, 1'b1, Typed, Silent, NoMove},
    // ignored fields all ones on a step
    {ACT_STEP,  13'h1FFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, Typed, Moves,
     {1'b1, 12'hFFF, 24'hFFFFFF, 1'b1, 1'b0}},
    // both pointers wrap to zero
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Typed, Moves,
     {1'b1, 12'h000, 24'h000000, 1'b1, 1'b0}},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    // eighth byte closes the job
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Typed, Moves,
     {1'b1, 12'h006, 24'h000006, 1'b1, 1'b1}},
    // job done: step is dropped
    {ACT_STEP,  13'h1FFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, Typed, Silent, NoMove},
    // 256 rows, max skip, data bank, toward local
    {ACT_START, 13'h0000, 24'h000000, 32'hFFFFF007, 1'b0, Typed, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Typed, Moves,
     {1'b0, 12'h000, 24'h000000, 1'b0, 1'b0}},
    // start while busy replaces the job; all-ones length word
    {ACT_START, 13'h1555, 24'hAAAAAA, 32'hFFFFFFFF, 1'b0, Typed, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Typed, Moves,
     {1'b1, 12'h555, 24'hAAAAAA, 1'b0, 1'b0}},
    // two rows of 8, max skip: the ninth byte lands after the skip
    {ACT_START, 13'h0AAA, 24'h555555, 32'hFFF01000, 1'b1, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove},
    {ACT_STEP,  13'h0000, 24'h000000, 32'h00000000, 1'b0, Predict, Silent, NoMove}
  };

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     cfg_valid_i     = 1'b0;
  logic                     cfg_ready_o;
  logic [SwzBits-1:0]       cfg_data_i      = '0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic                     action_i        = 1'b0;
  logic [12:0]              local_address_i = '0;
  logic [MainAddrBits-1:0]  main_address_i  = '0;
  logic [LenWordBits-1:0]   length_word_i   = '0;
  logic                     to_main_i       = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic                     bank_select_o;
  logic [LocalAddrBits-1:0] local_byte_o;
  logic [MainAddrBits-1:0]  main_byte_o;
  logic                     toward_main_o;
  logic                     final_move_o;

  strided_dma_address_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .local_address_i (local_address_i),
    .main_address_i  (main_address_i),
    .length_word_i   (length_word_i),
    .to_main_i       (to_main_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bank_select_o   (bank_select_o),
    .local_byte_o    (local_byte_o),
    .main_byte_o     (main_byte_o),
    .toward_main_o   (toward_main_o),
    .final_move_o    (final_move_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  dma_move_t   moves_due[$];    // expected moves, oldest first
  int          fails      = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_idle    = 1'b0;  // both sides run back to back
  bit          hold_req   = 1'b0;  // ask the sink for one long hold-off

  // Local copy of the generator state
  logic [SwzBits-1:0]       cur_swizzle = '0;
  logic                     job_busy    = 1'b0;
  logic [LocalAddrBits-1:0] lcl_ptr     = '0;
  logic [MainAddrBits-1:0]  mn_ptr      = '0;
  logic                     job_bank    = 1'b0;
  logic                     job_dir     = 1'b0;
  logic [RowLenBits-1:0]    row_len     = '0;
  logic [RowLenBits-1:0]    row_pos     = '0;
  logic [RowCntBits-1:0]    rows_to_go  = '0;
  logic [SkipBits-1:0]      job_skip    = '0;

  // Applies one accepted transfer; returns 1 when a move comes out.
  function automatic bit advance_dma(input dma_cmd_t c, output dma_move_t mv);
    logic row_done;
    mv = '0;
    if (c.action == ACT_START) begin
      // length rounds up to a whole 8-byte unit
      row_len    = {1'b0, c.length_word[11:0] | 12'h007} + 13'd1;
      rows_to_go = {1'b0, c.length_word[19:12]} + 9'd1;
      job_skip   = c.length_word[31:20];
      lcl_ptr    = c.local_address[LocalAddrBits-1:0];
      mn_ptr     = c.main_address;
      job_bank   = c.local_address[12];
      job_dir    = c.to_main;
      row_pos    = '0;
      job_busy   = 1'b1;
      return 1'b0;
    end
    if (!job_busy) return 1'b0;
    row_done       = (row_pos + 13'd1 == row_len);
    mv.bank_select = job_bank;
    mv.local_byte  = lcl_ptr ^ LocalAddrBits'(cur_swizzle);
    mv.main_byte   = mn_ptr ^ MainAddrBits'(cur_swizzle);
    mv.toward_main = job_dir;
    mv.final_move  = row_done && (rows_to_go == 9'd1);
    lcl_ptr = lcl_ptr + LocalAddrBits'(1);
    mn_ptr  = mn_ptr + MainAddrBits'(1);
    row_pos = row_pos + RowLenBits'(1);
    if (row_done) begin
      row_pos    = '0;
      mn_ptr     = mn_ptr + MainAddrBits'(job_skip);
      rows_to_go = rows_to_go - RowCntBits'(1);
      if (rows_to_go == '0) job_busy = 1'b0;
    end
    return 1'b1;
  endfunction

  // Step with junk in the ignored fields.
  function automatic dma_cmd_t rand_step();
    dma_cmd_t c;
    c.action        = ACT_STEP;
    c.local_address = 13'($urandom);
    c.main_address  = 24'($urandom);
    c.length_word   = $urandom;
    c.to_main       = 1'($urandom);
    return c;
  endfunction

  // Drives one transfer after a random gap, waits for acceptance, then
  // queues what it should produce. Entered and left on a falling edge.
  task automatic issue(input dma_cmd_t c, input logic typed, input logic yields,
                       input dma_move_t typed_mv);
    int unsigned gap;
    dma_move_t   mv;
    bit          produced;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i        <= c.action;
    local_address_i <= c.local_address;
    main_address_i  <= c.main_address;
    length_word_i   <= c.length_word;
    to_main_i       <= c.to_main;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
    produced = advance_dma(c, mv);
    if (typed) begin
      if (yields) moves_due.push_back(typed_mv);
    end else if (produced) begin
      moves_due.push_back(mv);
    end
  endtask

  // Waits for every queued move, then a few cycles for steps that produce
  // nothing but may still sit in the pipe.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_swizzle(input logic [SwzBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_swizzle = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random job: mostly a well-formed start plus its steps, sometimes
  // cut short or overrun; now and then plain noise.
  task automatic random_job();
    dma_cmd_t    c;
    int unsigned len_f, rows_f, total, steps;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) begin
        c = rand_step();
        if ($urandom_range(0, 2) == 0) c.action = ACT_START;
        issue(c, Predict, Silent, NoMove);
      end
      return;
    end
    c.action        = ACT_START;
    c.local_address = 13'($urandom);
    c.main_address  = 24'($urandom);
    c.to_main       = 1'($urandom);
    // bias some jobs right below the pointer wraps
    if ($urandom_range(0, 3) == 0)
      c.local_address[11:0] = 12'hFFF - 12'($urandom_range(0, 40));
    if ($urandom_range(0, 3) == 0)
      c.main_address = 24'hFFFFFF - 24'($urandom_range(0, 60));
    len_f  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 31);
    rows_f = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    c.length_word = {12'($urandom), 8'(rows_f), 12'(len_f)};
    total = ((len_f | 7) + 1) * (rows_f + 1);
    if (total > 200) begin
      steps = $urandom_range(1, 60);  // huge job: never finish, next start replaces
    end else begin
      steps = total;
      if ($urandom_range(0, 4) == 0) steps = $urandom_range(1, total);
      else if ($urandom_range(0, 5) == 0) steps = total + $urandom_range(1, 3);
    end
    issue(c, Predict, Silent, NoMove);
    repeat (steps) issue(rand_step(), Predict, Silent, NoMove);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    dma_move_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (moves_due.size() == 0) begin
        $display("%0t: unexpected move: local 0x%0h main 0x%0h final %0b", $time,
                 local_byte_o, main_byte_o, final_move_o);
        fails++;
      end else begin
        want = moves_due.pop_front();
        check_field("bank_select", 32'(want.bank_select), 32'(bank_select_o));
        check_field("local_byte", 32'(want.local_byte), 32'(local_byte_o));
        check_field("main_byte", 32'(want.main_byte), 32'(main_byte_o));
        check_field("toward_main", 32'(want.toward_main), 32'(toward_main_o));
        check_field("final_move", 32'(want.final_move), 32'(final_move_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall before each transfer, or one long hold-off
  // on request so the command queue backs up into the input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold     = LongHold;
        hold_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 13);
      end
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: cycle limit reached, %0d moves outstanding", $time, moves_due.size());
      $display("strided_dma_address_generator_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dma_cmd_t c;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_swizzle(3'd0);

    for (int i = 0; i < DirRows; i++)
      issue(DirTab[i].cmd, DirTab[i].typed, DirTab[i].yields, DirTab[i].mv);

    for (int ph = 0; ph < Phases; ph++) begin
      settle_idle();
      if (ph == 0)               set_swizzle(3'd7);
      else if (ph == Phases - 1) set_swizzle(3'd0);
      else                       set_swizzle(3'($urandom_range(0, 7)));
      if (ph == 1) begin
        // back-to-back job of two 32-byte rows against a held output
        no_idle         = 1'b1;
        hold_req        = 1'b1;
        c.action        = ACT_START;
        c.local_address = 13'($urandom);
        c.main_address  = 24'($urandom);
        c.length_word   = {12'($urandom), 8'd1, 12'd31};
        c.to_main       = 1'b1;
        issue(c, Predict, Silent, NoMove);
        repeat (64) issue(rand_step(), Predict, Silent, NoMove);
      end
      while (items_sent < DirRows + (ph + 1) * ItemsPerPhase) random_job();
    end

    settle_idle();
    repeat (20) @(negedge clk_i);
    if (fails == 0) begin
      $display("strided_dma_address_generator_tb OK");
    end else begin
      $display("strided_dma_address_generator_tb NOT OK");
    end
    $finish;
  end

endmodule
